### rtl/stream_string_replace_defines.svh
// Assertion macros shared by the stream search-and-replace RTL.
`ifndef STREAM_STRING_REPLACE_DEFINES_SVH
`define STREAM_STRING_REPLACE_DEFINES_SVH

// Property checked at every clock edge, ignored while reset is held.
`define SSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// Condition in one cycle that requires another condition in the next cycle.
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### rtl/ssr_pkg.sv
// Shared types and constants of the stream search-and-replace block.
package ssr_pkg;

	// Largest run of output beats one item can cause.
	localparam int RUN_MAX = 16;
	localparam int RUN_CW  = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic [7:0] NEWLINE = 8'd10;

	typedef enum logic [1:0] {
		OP_TEXT = 2'd0,
		OP_EOL  = 2'd1,
		OP_EOI  = 2'd2
	} opcode_t;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_HIGH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN  = 3'd5;

	typedef struct packed {
		logic [127:0]      pattern;
		logic [RUN_CW-1:0] pat_len;
		logic [127:0]      replacement;
		logic [RUN_CW-1:0] rep_len;
	} cfg_t;

	// A run of result bytes handed from the matcher to the output stage.
	typedef struct packed {
		logic                  valid;
		logic [8*RUN_MAX-1:0]  bytes;
		logic [RUN_CW-1:0]     len;
	} run_t;

	// Matcher state exposed for checking.
	typedef struct packed {
		logic [RUN_CW-1:0] count;
		logic [RUN_CW-1:0] active;
	} status_t;

endpackage

### rtl/ssr_cfg.sv
// Configuration register file of the stream search-and-replace block.
module ssr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                    cfg_data,
	output ssr_pkg::cfg_t                  cfg
);

	ssr_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern     <= '0;
			cfg_q.pat_len     <= ssr_pkg::RUN_CW'(1);
			cfg_q.replacement <= '0;
			cfg_q.rep_len     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ssr_pkg::REG_PATTERN_LOW:      cfg_q.pattern[63:0]       <= cfg_data;
				ssr_pkg::REG_PATTERN_HIGH:     cfg_q.pattern[127:64]     <= cfg_data;
				ssr_pkg::REG_PATTERN_LENGTH:   cfg_q.pat_len             <= cfg_data[4:0];
				ssr_pkg::REG_REPLACEMENT_LOW:  cfg_q.replacement[63:0]   <= cfg_data;
				ssr_pkg::REG_REPLACEMENT_HIGH: cfg_q.replacement[127:64] <= cfg_data;
				ssr_pkg::REG_REPLACEMENT_LEN:  cfg_q.rep_len             <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/ssr_core.sv
// Input register, match window and per-item decision of the search-and-replace block.
module ssr_core #(
	parameter int PATTERN_MAX = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic [1:0]        s_tuser,
	input  ssr_pkg::cfg_t     cfg,
	input  logic              run_free,
	output ssr_pkg::run_t     run_load,
	output ssr_pkg::status_t  status
);

	localparam int CW = $clog2(PATTERN_MAX + 1);
	localparam int RW = ssr_pkg::RUN_CW;

	logic       v_s1;
	logic [1:0] op_s1;
	logic [7:0] byte_s1;

	logic [7:0]    win_q [PATTERN_MAX];
	logic [CW-1:0] count_q;
	logic [CW-1:0] active_q;
	logic          line_open_q;

	logic [7:0]    win_new [PATTERN_MAX];
	logic [7:0]    win_d   [PATTERN_MAX];
	logic [CW-1:0] count_d;
	logic [CW-1:0] active_d;
	logic          open_d;

	logic [CW-1:0] req_len;
	logic [CW-1:0] act_eff;
	logic [CW-1:0] count_inc;
	logic          hit;
	logic          full;
	logic [RW-1:0] rep_sat;

	logic [8*ssr_pkg::RUN_MAX-1:0] win_flat;
	logic [8*ssr_pkg::RUN_MAX-1:0] flush_vec;

	logic                          ld_valid;
	logic [8*ssr_pkg::RUN_MAX-1:0] ld_bytes;
	logic [RW-1:0]                 ld_len;
	logic                          step;

	assign s_tready = !v_s1 || run_free;
	assign step     = v_s1 && run_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// Pattern length as requested: zero acts as one, long values saturate.
	always_comb begin
		if (cfg.pat_len == '0) begin
			req_len = CW'(1);
		end else if (cfg.pat_len > RW'(PATTERN_MAX)) begin
			req_len = CW'(PATTERN_MAX);
		end else begin
			req_len = cfg.pat_len[CW-1:0];
		end
	end

	assign rep_sat   = (cfg.rep_len > RW'(ssr_pkg::RUN_MAX)) ? RW'(ssr_pkg::RUN_MAX)
	                                                           : cfg.rep_len;
	assign act_eff   = (count_q == '0) ? req_len : active_q;
	assign count_inc = count_q + CW'(1);
	assign full      = count_inc >= act_eff;

	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			win_new[i] = (CW'(i) == count_q) ? byte_s1 : win_q[i];
			if (CW'(i) < act_eff && win_new[i] != cfg.pattern[8*i +: 8]) begin
				hit = 1'b0;
			end
		end
	end

	// Held bytes followed by a newline, as sent at the end of a line.
	always_comb begin
		win_flat = '0;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			win_flat[8*i +: 8] = win_q[i];
		end
		flush_vec = '0;
		for (int i = 0; i < ssr_pkg::RUN_MAX; i++) begin
			if (RW'(i) < RW'(count_q)) begin
				flush_vec[8*i +: 8] = win_flat[8*i +: 8];
			end else if (RW'(i) == RW'(count_q)) begin
				flush_vec[8*i +: 8] = ssr_pkg::NEWLINE;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			win_d[i] = win_q[i];
		end
		count_d  = count_q;
		active_d = active_q;
		open_d   = line_open_q;
		ld_valid = 1'b0;
		ld_bytes = '0;
		ld_len   = '0;
		case (op_s1)
			ssr_pkg::OP_TEXT: begin
				active_d = act_eff;
				open_d   = 1'b1;
				if (!full) begin
					for (int i = 0; i < PATTERN_MAX; i++) begin
						win_d[i] = win_new[i];
					end
					count_d = count_inc;
				end else if (hit) begin
					count_d  = '0;
					ld_valid = rep_sat != '0;
					ld_bytes = cfg.replacement;
					ld_len   = rep_sat;
				end else begin
					// Oldest byte leaves; the rest move down one place.
					for (int i = 0; i < PATTERN_MAX - 1; i++) begin
						win_d[i] = win_new[i + 1];
					end
					win_d[PATTERN_MAX-1] = win_new[PATTERN_MAX-1];
					ld_valid = 1'b1;
					ld_bytes = {{(8*(ssr_pkg::RUN_MAX-1)){1'b0}}, win_new[0]};
					ld_len   = RW'(1);
				end
			end
			ssr_pkg::OP_EOL: begin
				ld_valid = 1'b1;
				ld_bytes = flush_vec;
				ld_len   = RW'(count_q) + RW'(1);
				count_d  = '0;
				open_d   = 1'b0;
			end
			ssr_pkg::OP_EOI: begin
				ld_valid = line_open_q;
				ld_bytes = flush_vec;
				ld_len   = RW'(count_q) + RW'(1);
				count_d  = '0;
				open_d   = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			active_q    <= CW'(1);
			line_open_q <= 1'b0;
		end else if (step) begin
			count_q     <= count_d;
			active_q    <= active_d;
			line_open_q <= open_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				win_q[i] <= win_d[i];
			end
		end
	end

	assign run_load.valid = step && ld_valid;
	assign run_load.bytes = ld_bytes;
	assign run_load.len   = ld_len;
	assign status.count   = RW'(count_q);
	assign status.active  = RW'(active_q);

endmodule

### rtl/ssr_emit.sv
// Output run register of the search-and-replace block, one byte per beat.
module ssr_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  ssr_pkg::run_t run_load,
	output logic          run_free,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic          m_tlast
);

	logic [8*ssr_pkg::RUN_MAX-1:0] bytes_q;
	logic [ssr_pkg::RUN_CW-1:0]    cnt_q;
	logic                          take;

	assign m_tvalid = cnt_q != '0;
	assign m_tlast  = cnt_q == ssr_pkg::RUN_CW'(1);
	assign m_tdata  = bytes_q[7:0];
	assign take     = m_tvalid && m_tready;
	// A new run may be loaded as the last beat of the current one leaves.
	assign run_free = !m_tvalid || (m_tlast && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (run_load.valid) begin
			cnt_q <= run_load.len;
		end else if (take) begin
			cnt_q <= cnt_q - ssr_pkg::RUN_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (run_load.valid) begin
			bytes_q <= run_load.bytes;
		end else if (take) begin
			bytes_q <= bytes_q >> 8;
		end
	end

endmodule

### rtl/stream_string_replace.sv
// Top level of the streaming search-and-replace block.
//
// This block rewrites a byte stream line by line, replacing every leftmost,
// non-overlapping occurrence of a programmed pattern (1 to PATTERN_MAX bytes)
// with a programmed replacement of 0 to 16 bytes; replaced text is not
// rescanned and a match never spans a line. Each input beat carries a text
// byte, an end-of-line mark or an end-of-input mark; each output beat carries
// one byte, with tlast set on the final byte caused by one input beat. A text
// beat causes no output until the window holds a full pattern length, then
// one byte (mismatch) or the replacement (match); an end-of-line beat
// releases the held bytes plus a newline, and end of input does the same for
// an unterminated line. Every input beat passes one input register and the
// match logic, so a beat is taken every cycle as long as each beat causes at
// most one output byte and the output is not stalled; a beat that causes a run
// of N bytes stalls the input while the output run register shifts them out.
// There is no warm-up after reset. The pattern length in force changes only
// when a text byte arrives with the window empty; all configuration writes
// must be made while the block is idle.
module stream_string_replace #(
	parameter int PATTERN_MAX = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,   // last_of_run
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

`include "stream_string_replace_defines.svh"

	ssr_pkg::cfg_t    cfg;
	ssr_pkg::run_t    run_load;
	ssr_pkg::status_t status;
	logic             run_free;

	// Register file: pattern, replacement and their lengths.
	ssr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register, window and the match decision for each beat.
	ssr_core #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg      (cfg),
		.run_free (run_free),
		.run_load (run_load),
		.status   (status)
	);

	// Output run register that sends one byte per beat.
	ssr_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.run_load (run_load),
		.run_free (run_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// The window never holds more bytes than the pattern length in force.
	`SSR_ASSERT(a_window_bound, (status.count <= status.active) && (status.active != '0), "window count exceeds active pattern length")
	// A run is only loaded when the output register is free to take it.
	`SSR_ASSERT(a_load_free, !run_load.valid || run_free, "run loaded while output busy")
	// After a run ends, output continues only if a new run was loaded.
	`SSR_ASSERT_NEXT(a_run_end, m_tvalid && m_tready && m_tlast, !m_tvalid || $past(run_load.valid), "output beat without a loaded run")

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the streaming search-and-replace block.
module testbench;

	// The two-bit opcode field has one code that no enum member names; the block ignores it.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Cycles allowed after the last expected beat for beats still in flight.
	localparam int DRAIN_SLACK = 8;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// While set, neither side idles.
	logic steady = 1'b0;
	int   failures = 0;

	// Shadow copy of the registers, at their reset values.
	logic [127:0] pattern_bits = '0;
	logic [4:0]   pattern_len_reg = 5'd1;
	logic [127:0] repl_bits = '0;
	logic [4:0]   repl_len_reg = 5'd0;

	// Shadow copy of the matcher state.
	logic [7:0] win_bytes [16];
	int         win_count = 0;
	logic       line_open = 1'b0;
	int         len_in_force = 1;

	// Output beats predicted but not yet seen, oldest first.
	out_beat_t expected_out[$];

	stream_string_replace #(.PATTERN_MAX(16)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The output side stalls about ten percent of the time unless a steady stretch is on.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 10);
	end

	// Every output beat is checked against the oldest prediction.
	always @(posedge clk) begin : check_output
		out_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_out.size() == 0) begin
				if (failures < 10) begin
					$display("unexpected output beat: data %02h last %0b", m_tdata, m_tlast);
				end
				failures++;
			end else begin
				want = expected_out.pop_front();
				if (m_tdata !== want.data || m_tlast !== want.last) begin
					if (failures < 10) begin
						$display("output mismatch: expected data %02h last %0b, got data %02h last %0b",
							want.data, want.last, m_tdata, m_tlast);
					end
					failures++;
				end
			end
		end
	end

	// Works out the output beats that one input beat causes and queues them.
	function automatic void predict_item(input logic [1:0] op, input logic [7:0] ch);
		out_beat_t run[$];
		logic hit;
		int n;
		if (op == ssr_pkg::OP_TEXT) begin
			// A new pattern length only takes hold when a window starts.
			if (win_count == 0) begin
				if (pattern_len_reg == 0) begin
					len_in_force = 1;
				end else if (pattern_len_reg > 16) begin
					len_in_force = 16;
				end else begin
					len_in_force = pattern_len_reg;
				end
			end
			line_open = 1'b1;
			win_bytes[win_count] = ch;
			win_count++;
			if (win_count >= len_in_force) begin
				hit = 1'b1;
				for (int i = 0; i < len_in_force; i++) begin
					if (win_bytes[i] != pattern_bits[8*i +: 8]) begin
						hit = 1'b0;
					end
				end
				if (hit) begin
					n = (repl_len_reg > 16) ? 16 : repl_len_reg;
					for (int i = 0; i < n; i++) begin
						run.push_back('{repl_bits[8*i +: 8], 1'b0});
					end
					win_count = 0;
				end else begin
					// No match: the oldest held byte leaves and the window slides.
					run.push_back('{win_bytes[0], 1'b0});
					for (int i = 0; i < 15; i++) begin
						win_bytes[i] = win_bytes[i+1];
					end
					win_count--;
				end
			end
		end else if (op == ssr_pkg::OP_EOL || (op == ssr_pkg::OP_EOI && line_open)) begin
			for (int i = 0; i < win_count; i++) begin
				run.push_back('{win_bytes[i], 1'b0});
			end
			run.push_back('{ssr_pkg::NEWLINE, 1'b0});
		end
		if (op == ssr_pkg::OP_EOL || op == ssr_pkg::OP_EOI) begin
			win_count = 0;
			line_open = 1'b0;
		end
		if (run.size() > 0) begin
			run[run.size()-1].last = 1'b1;
		end
		foreach (run[i]) begin
			expected_out.push_back(run[i]);
		end
	endfunction

	// Sends one input beat, now and then after a one-cycle idle gap.
	task automatic send_item(input logic [1:0] op, input logic [7:0] ch);
		if (!steady && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= ch;
		predict_item(op, ch);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Holds the input until every predicted beat is out, plus some slack for
	// beats that cause nothing but are still in the pipeline.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_out.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// One configuration write; the caller lowers cfg_valid after its last write.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			ssr_pkg::REG_PATTERN_LOW: begin
				pattern_bits[63:0] = val;
			end
			ssr_pkg::REG_PATTERN_HIGH: begin
				pattern_bits[127:64] = val;
			end
			ssr_pkg::REG_PATTERN_LENGTH: begin
				pattern_len_reg = val[4:0];
			end
			ssr_pkg::REG_REPLACEMENT_LOW: begin
				repl_bits[63:0] = val;
			end
			ssr_pkg::REG_REPLACEMENT_HIGH: begin
				repl_bits[127:64] = val;
			end
			ssr_pkg::REG_REPLACEMENT_LEN: begin
				repl_len_reg = val[4:0];
			end
			default: begin
			end
		endcase
	endtask

	// Programs all six registers once the block has gone idle. The length
	// writes carry random junk above bit 4, which the block must drop.
	task automatic load_setting(input logic [127:0] pat, input logic [4:0] plen,
			input logic [127:0] rep, input logic [4:0] rlen);
		logic [63:0] junk;
		wait_idle();
		junk = {$urandom, $urandom};
		write_reg(ssr_pkg::REG_PATTERN_LOW, pat[63:0]);
		write_reg(ssr_pkg::REG_PATTERN_HIGH, pat[127:64]);
		write_reg(ssr_pkg::REG_PATTERN_LENGTH, {junk[63:5], plen});
		write_reg(ssr_pkg::REG_REPLACEMENT_LOW, rep[63:0]);
		write_reg(ssr_pkg::REG_REPLACEMENT_HIGH, rep[127:64]);
		write_reg(ssr_pkg::REG_REPLACEMENT_LEN, {junk[58:0], rlen});
		cfg_valid <= 1'b0;
	endtask

	// Random text built mostly from pattern bytes and whole occurrences so that
	// matches, near misses and long held windows are common.
	task automatic stream_text(input int budget);
		int sent;
		int pick;
		int n;
		int len;
		if (pattern_len_reg == 0) begin
			len = 1;
		end else if (pattern_len_reg > 16) begin
			len = 16;
		end else begin
			len = pattern_len_reg;
		end
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				// A whole occurrence, or now and then only a prefix of one.
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : len;
				for (int k = 0; k < n; k++) begin
					send_item(ssr_pkg::OP_TEXT, pattern_bits[8*k +: 8]);
				end
				sent += n;
			end else if (pick < 27) begin
				send_item(ssr_pkg::OP_EOL, 8'($urandom));
				sent++;
			end else if (pick < 29) begin
				send_item(ssr_pkg::OP_EOI, 8'($urandom));
				sent++;
			end else if (pick < 31) begin
				// Ignored by the block, so it does not count.
				send_item(OP_UNUSED, 8'($urandom));
			end else if (pick < 32) begin
				wait_idle();
			end else if (pick < 85) begin
				send_item(ssr_pkg::OP_TEXT, pattern_bits[8*$urandom_range(0, len-1) +: 8]);
				sent++;
			end else begin
				send_item(ssr_pkg::OP_TEXT, 8'($urandom));
				sent++;
			end
		end
	endtask

	// Reset values: the pattern is one zero byte and the replacement is empty,
	// so zero bytes are deleted and everything else passes through.
	task automatic test_reset_defaults();
		send_item(ssr_pkg::OP_TEXT, 8'h00);
		send_item(ssr_pkg::OP_TEXT, 8'hFF);
		send_item(ssr_pkg::OP_EOL, 8'h00);
		send_item(ssr_pkg::OP_EOI, 8'hFF);
		send_item(OP_UNUSED, 8'h5A);
	endtask

	// Pattern "aba" replaced by "XY": leftmost non-overlapping matches, held bytes
	// flushed at end of line, an unterminated line closed by end of input, an
	// empty line and end of input with no line open.
	task automatic test_match_and_flush();
		load_setting({64'($urandom) << 32, 64'h0000_0000_0061_6261}, 5'd3,
			{64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_5958}, 5'd2);
		send_item(ssr_pkg::OP_TEXT, 8'h61);
		send_item(ssr_pkg::OP_TEXT, 8'h62);
		send_item(ssr_pkg::OP_TEXT, 8'h61);
		send_item(ssr_pkg::OP_TEXT, 8'h62);
		send_item(ssr_pkg::OP_TEXT, 8'h61);
		send_item(ssr_pkg::OP_EOL, 8'h00);
		send_item(ssr_pkg::OP_TEXT, 8'h61);
		send_item(ssr_pkg::OP_TEXT, 8'h61);
		send_item(ssr_pkg::OP_TEXT, 8'h62);
		send_item(ssr_pkg::OP_EOI, 8'h00);
		send_item(ssr_pkg::OP_EOL, 8'hFF);
		send_item(ssr_pkg::OP_EOI, 8'h00);
	endtask

	// A pattern length written while bytes are held waits for the window to
	// empty, but new pattern bytes apply to the held window at once.
	task automatic test_length_change_mid_window();
		load_setting({64'h0, 64'h0000_0000_0063_6261}, 5'd3, {64'h0, 64'h5A}, 5'd1);
		send_item(ssr_pkg::OP_TEXT, 8'h61);
		send_item(ssr_pkg::OP_TEXT, 8'h62);
		wait_idle();
		write_reg(ssr_pkg::REG_PATTERN_LENGTH, 64'd1);
		write_reg(ssr_pkg::REG_PATTERN_LOW, 64'h0000_0000_0064_6261);
		cfg_valid <= 1'b0;
		send_item(ssr_pkg::OP_TEXT, 8'h64);
		send_item(ssr_pkg::OP_TEXT, 8'h61);
		send_item(ssr_pkg::OP_EOL, 8'h00);
	endtask

	// Random text under several settings, the length extremes and the
	// saturating length codes among them; one phase runs with no idling.
	task automatic test_random_settings();
		logic [127:0] pat;
		logic [127:0] rep;
		logic [4:0]   plen;
		logic [4:0]   rlen;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					plen = 5'd1;
					rlen = 5'd0;
				end
				1: begin
					plen = 5'd16;
					rlen = 5'd16;
				end
				2: begin
					plen = 5'd0;
					rlen = 5'd31;
				end
				3: begin
					plen = 5'd31;
					rlen = 5'd1;
				end
				4: begin
					plen = 5'd2;
					rlen = 5'd5;
				end
				default: begin
					plen = 5'($urandom_range(1, 16));
					rlen = 5'($urandom_range(0, 16));
				end
			endcase
			// Even phases draw the pattern from three letters, so it often
			// overlaps itself; odd phases use any byte.
			for (int k = 0; k < 16; k++) begin
				pat[8*k +: 8] = (ph % 2 == 0) ? 8'(8'h61 + $urandom_range(0, 2))
					: 8'($urandom);
			end
			rep = {$urandom, $urandom, $urandom, $urandom};
			load_setting(pat, plen, rep, rlen);
			steady = (ph == 2);
			stream_text(52);
		end
		wait_idle();
		steady = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_match_and_flush();
		test_length_change_mid_window();
		test_random_settings();
		wait_idle();
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Hard limit, far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule
